>>> hdl/cube_map_face_select_assert.svh
`ifndef CUBE_MAP_FACE_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CMFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CMFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cmfs_pkg.sv
package cmfs_pkg;

    localparam int COMPONENT_BITS  = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int DETAIL_W        = 8;
    localparam int FACE_W          = 3;

    localparam int NUM_W   = COMPONENT_BITS + 1;
    localparam int REM_W   = COMPONENT_BITS + COORD_FRAC_BITS + 2;
    localparam int COORD_W = COORD_FRAC_BITS + 1;
    localparam int STAGES  = COORD_FRAC_BITS + 1;

    localparam logic [COORD_W-1:0] COORD_ONE = {1'b1, {COORD_FRAC_BITS{1'b0}}};

    localparam int IN_FIELDS_W  = 3 * COMPONENT_BITS + DETAIL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = FACE_W + 2 * COORD_W + DETAIL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // One classified direction waiting for the divider.
    typedef struct packed {
        face_t                     face;
        logic [NUM_W-1:0]          num_u;
        logic [NUM_W-1:0]          num_v;
        logic [COMPONENT_BITS-1:0] mag;
        logic [DETAIL_W-1:0]       detail;
        logic                      zero;
    } queue_entry_t;

    // State of one item inside the divider pipeline.
    typedef struct packed {
        face_t               face;
        logic [DETAIL_W-1:0] detail;
        logic                zero;
        logic [NUM_W-1:0]    den;
        logic [REM_W-1:0]    rem_u;
        logic [REM_W-1:0]    rem_v;
        logic [COORD_W-1:0]  q_u;
        logic [COORD_W-1:0]  q_v;
    } div_stage_t;

endpackage

>>> hdl/cube_map_face_select.sv
// Cube map face selection: each input beat carries a signed direction (x, y, z) and a
// level of detail; each output beat gives the cube face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z,
// 5 -z), the face coordinates u and v in unsigned fixed point where 65536 stands for 1.0
// (rounded to nearest, halves up), and the level of detail unchanged. The largest
// magnitude picks the face, with ties going to x, then y, then z. An all-zero direction
// gives an output beat with the zero_vector flag set in tuser and every tdata field zero.
// The block takes one beat per clock cycle while the output side is ready. Each beat is
// classified into a four-entry queue and then passes through the divider pipeline,
// which resolves one quotient bit of u and v per stage. While the
// output is stalled the divider holds and the queue absorbs up to four more beats.
module cube_map_face_select (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0 up: dir_x[15:0], dir_y[31:16], dir_z[47:32],
    // detail_level[55:48].
    input  logic [cmfs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: face_index[2:0], coord_u[19:3], coord_v[36:20],
    // detail_out[44:37], zero fill[47:45].
    output logic [cmfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: zero_vector, set when all three components are zero.
    output logic                            m_tuser
);
    import cmfs_pkg::*;

    logic         push;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop;
    logic         head_valid;
    queue_entry_t head_entry;

    // Front: magnitude compare, face choice and the two numerators m +/- comp.
    cmfs_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .queue_ready (push_ready),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Short queue that lets the front keep taking beats while the back is stalled.
    cmfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (head_valid),
        .pop_entry  (head_entry)
    );

    // Back: pipelined division (num * 65536 + m) / (2m) for u and v side by side.
    cmfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

>>> hdl/cmfs_front.sv
module cmfs_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cmfs_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           queue_ready,
    output logic                           push,
    output cmfs_pkg::queue_entry_t         push_entry
);
    import cmfs_pkg::*;

    localparam int CB = COMPONENT_BITS;

    logic [CB-1:0]       x_raw, y_raw, z_raw;
    logic [DETAIL_W-1:0] detail;
    logic [CB-1:0]       ax, ay, az, mag;
    logic                x_major, y_major;
    logic [CB-1:0]       comp_u, comp_v;
    logic                neg_u, neg_v;
    logic signed [CB+1:0] sum_u, sum_v;
    face_t               face;

    assign x_raw  = s_tdata[CB-1:0];
    assign y_raw  = s_tdata[2*CB-1:CB];
    assign z_raw  = s_tdata[3*CB-1:2*CB];
    assign detail = s_tdata[3*CB+DETAIL_W-1:3*CB];

    // The most negative input has a magnitude that still fits in CB unsigned bits.
    assign ax = x_raw[CB-1] ? (~x_raw + 1'b1) : x_raw;
    assign ay = y_raw[CB-1] ? (~y_raw + 1'b1) : y_raw;
    assign az = z_raw[CB-1] ? (~z_raw + 1'b1) : z_raw;

    assign x_major = (ax >= ay) && (ax >= az);
    assign y_major = !x_major && (ay >= az);

    always_comb
    begin
        priority if (x_major)
        begin
            mag    = ax;
            face   = x_raw[CB-1] ? FACE_NEG_X : FACE_POS_X;
            comp_u = z_raw;
            neg_u  = !x_raw[CB-1];
            comp_v = y_raw;
            neg_v  = 1'b1;
        end
        else if (y_major)
        begin
            mag    = ay;
            face   = y_raw[CB-1] ? FACE_NEG_Y : FACE_POS_Y;
            comp_u = x_raw;
            neg_u  = 1'b0;
            comp_v = z_raw;
            neg_v  = y_raw[CB-1];
        end
        else
        begin
            mag    = az;
            face   = z_raw[CB-1] ? FACE_NEG_Z : FACE_POS_Z;
            comp_u = x_raw;
            neg_u  = z_raw[CB-1];
            comp_v = y_raw;
            neg_v  = 1'b1;
        end
    end

    // The numerator m +/- comp lies between zero and 2m, so CB+1 bits hold it.
    assign sum_u = neg_u ? ($signed({2'b00, mag}) - $signed({{2{comp_u[CB-1]}}, comp_u}))
                         : ($signed({2'b00, mag}) + $signed({{2{comp_u[CB-1]}}, comp_u}));
    assign sum_v = neg_v ? ($signed({2'b00, mag}) - $signed({{2{comp_v[CB-1]}}, comp_v}))
                         : ($signed({2'b00, mag}) + $signed({{2{comp_v[CB-1]}}, comp_v}));

    assign s_tready = queue_ready;
    assign push     = s_tvalid && queue_ready;

    always_comb
    begin
        push_entry.face   = face;
        push_entry.num_u  = sum_u[NUM_W-1:0];
        push_entry.num_v  = sum_v[NUM_W-1:0];
        push_entry.mag    = mag;
        push_entry.detail = detail;
        push_entry.zero   = (mag == '0);
    end

endmodule

>>> hdl/cmfs_queue.sv
`include "cube_map_face_select_assert.svh"

module cmfs_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cmfs_pkg::queue_entry_t push_entry,
    output logic                   push_ready,
    input  logic                   pop,
    output logic                   pop_valid,
    output cmfs_pkg::queue_entry_t pop_entry
);
    import cmfs_pkg::*;

    queue_entry_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QUEUE_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `CMFS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `CMFS_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")
    `CMFS_ASSERT_NXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "push did not grow queue")

endmodule

>>> hdl/cmfs_back.sv
`include "cube_map_face_select_assert.svh"

module cmfs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  cmfs_pkg::queue_entry_t          head_entry,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cmfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser
);
    import cmfs_pkg::*;

    div_stage_t stage_reg [STAGES];
    logic       valid_reg [STAGES];
    div_stage_t init;
    logic       ce;
    div_stage_t last;
    face_t      face_out;
    logic [COORD_W-1:0]  u_out, v_out;
    logic [DETAIL_W-1:0] detail_out;

    // The whole pipeline moves together unless a finished beat is held at the output.
    assign ce  = !valid_reg[STAGES-1] || m_tready;
    assign pop = ce && head_valid;

    always_comb
    begin
        init.face   = head_entry.face;
        init.detail = head_entry.detail;
        init.zero   = head_entry.zero;
        init.den    = {head_entry.mag, 1'b0};
        init.rem_u  = REM_W'({head_entry.num_u, {COORD_FRAC_BITS{1'b0}}}) + REM_W'(head_entry.mag);
        init.rem_v  = REM_W'({head_entry.num_v, {COORD_FRAC_BITS{1'b0}}}) + REM_W'(head_entry.mag);
        init.q_u    = '0;
        init.q_v    = '0;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int SH = COORD_FRAC_BITS - k;
        div_stage_t       cur;
        div_stage_t       stage_next;
        logic [REM_W-1:0] sden;

        if (k == 0)
        begin : g_first
            assign cur = init;
        end
        else
        begin : g_rest
            assign cur = stage_reg[k-1];
        end

        assign sden = REM_W'(cur.den) << SH;

        always_comb
        begin
            stage_next = cur;
            if (cur.rem_u >= sden)
            begin
                stage_next.rem_u  = cur.rem_u - sden;
                stage_next.q_u[SH] = 1'b1;
            end
            if (cur.rem_v >= sden)
            begin
                stage_next.rem_v  = cur.rem_v - sden;
                stage_next.q_v[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_reg[0] <= head_valid;
            for (int i = 1; i < STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // A zero vector has no major axis; its divider result is discarded here.
    assign last       = stage_reg[STAGES-1];
    assign face_out   = last.zero ? FACE_POS_X : last.face;
    assign u_out      = last.zero ? '0 : last.q_u;
    assign v_out      = last.zero ? '0 : last.q_v;
    assign detail_out = last.zero ? '0 : last.detail;

    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tuser  = last.zero;
    assign m_tdata  = OUT_TDATA_W'({detail_out, v_out, u_out, face_out});

    `CMFS_ASSERT_IMP(a_zero_clean, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0, "zero vector beat carries data")
    `CMFS_ASSERT_IMP(a_coord_range, clk, rst_n, m_tvalid, (u_out <= COORD_ONE) && (v_out <= COORD_ONE), "face coordinate above one")

endmodule
